FILE: hdl/sepu_pkg.sv
// Shared constants for the stereo emitter placement unit.
package sepu_pkg;

  // Fixed field widths.
  localparam int unsigned DataW = 32;
  localparam int unsigned CfgW  = 31;
  localparam int unsigned IdxW  = 3;

  // Zone codes reported with each result.
  localparam logic [1:0] ZONE_AMBIENT = 2'd0;
  localparam logic [1:0] ZONE_LOCAL   = 2'd1;
  localparam logic [1:0] ZONE_BLEND   = 2'd2;

  // Configuration register indexes.
  localparam logic [IdxW-1:0] REG_AMBIENT  = 3'd0;
  localparam logic [IdxW-1:0] REG_TRANS    = 3'd1;
  localparam logic [IdxW-1:0] REG_MAX_SEP  = 3'd2;
  localparam logic [IdxW-1:0] REG_MIN_SEP  = 3'd3;
  localparam logic [IdxW-1:0] REG_TANGENT  = 3'd4;
  localparam logic [IdxW-1:0] REG_LEFT     = 3'd5;

endpackage

FILE: hdl/stereo_emitter_placement_unit.sv
// Top level of the stereo emitter placement unit: fully pipelined datapath.
//
//  channel   signals                                   handshake
//  --------  ----------------------------------------  ---------------------------
//  item in   listener/facing/up/source x,y,z           start && !busy
//  result    placed_x/y/z, zone                        done strobe, one cycle
//  config    cfg_index, cfg_data                       cfg_valid && cfg_ready
//
// A new item can enter every clock cycle; busy stays low. Each result passes
// through 65 register stages from the edge that accepts its transaction, of
// which the square root holds 34 and the divider 18.
// Synchronous reset clears the configuration registers and all valid bits.
// The receiver cannot stall, so the pipeline never holds.
module stereo_emitter_placement_unit
  import sepu_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [DataW-1:0] listener_x,
  input  logic signed [DataW-1:0] listener_y,
  input  logic signed [DataW-1:0] listener_z,
  input  logic signed [DataW-1:0] facing_x,
  input  logic signed [DataW-1:0] facing_y,
  input  logic signed [DataW-1:0] facing_z,
  input  logic signed [DataW-1:0] up_x,
  input  logic signed [DataW-1:0] up_y,
  input  logic signed [DataW-1:0] up_z,
  input  logic signed [DataW-1:0] source_x,
  input  logic signed [DataW-1:0] source_y,
  input  logic signed [DataW-1:0] source_z,
  output logic                    done,
  output logic signed [DataW-1:0] placed_x,
  output logic signed [DataW-1:0] placed_y,
  output logic signed [DataW-1:0] placed_z,
  output logic [1:0]              zone,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [IdxW-1:0]         cfg_index,
  input  logic [DataW-1:0]        cfg_data
);

  localparam int SqW  = 66;
  localparam int RtW  = SqW / 2;
  localparam int NumW = 47;
  localparam int DenW = 32;
  localparam int QW   = 17;
  localparam int DivLanes = 6;

  typedef struct packed {
    logic [2:0][31:0] lis;
    logic [2:0][31:0] src;
    logic [2:0][30:0] na;
    logic [1:0][30:0] nl;
    logic [2:0]       nega;
    logic [1:0]       negl;
    logic             zeroa;
    logic             zerol;
  } mid_t;

  typedef struct packed {
    logic [2:0][31:0] lis;
    logic [2:0][31:0] src;
    logic [2:0]       nega;
    logic [1:0]       negl;
    logic             zeroa;
    logic             zerol;
    logic [30:0]      dist_out;
    logic [1:0]       zone;
  } post_t;

  // Configuration registers.
  logic [CfgW-1:0] ambient_distance, transition_width, max_separation;
  logic [CfgW-1:0] min_separation, separation_tangent;
  logic            left_channel;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ambient_distance   <= '0;
      transition_width   <= '0;
      max_separation     <= '0;
      min_separation     <= '0;
      separation_tangent <= '0;
      left_channel       <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_AMBIENT: ambient_distance   <= cfg_data[CfgW-1:0];
        REG_TRANS:   transition_width   <= cfg_data[CfgW-1:0];
        REG_MAX_SEP: max_separation     <= cfg_data[CfgW-1:0];
        REG_MIN_SEP: min_separation     <= cfg_data[CfgW-1:0];
        REG_TANGENT: separation_tangent <= cfg_data[CfgW-1:0];
        REG_LEFT:    left_channel       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Valid bits for the stages outside the shared units.
  logic v1, v2, v3, v4, v5, v6, v8, v9, v10, v11, v12, v13;

  // Stage 1: capture the transaction.
  logic signed [31:0] lis1 [3], fac1 [3], up1 [3], src1 [3];

  always_ff @(posedge clk) begin
    lis1[0] <= listener_x; lis1[1] <= listener_y; lis1[2] <= listener_z;
    fac1[0] <= facing_x;   fac1[1] <= facing_y;   fac1[2] <= facing_z;
    up1[0]  <= up_x;       up1[1]  <= up_y;       up1[2]  <= up_z;
    src1[0] <= source_x;   src1[1] <= source_y;   src1[2] <= source_z;
  end

  // Stage 2: listener-to-source difference and cross product terms.
  logic signed [32:0] d2 [3];
  logic signed [63:0] pa2 [3], pb2 [3];
  logic signed [31:0] lis2 [3], src2 [3];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      d2[k]   <= 33'(lis1[k]) - 33'(src1[k]);
      lis2[k] <= lis1[k];
      src2[k] <= src1[k];
    end
    pa2[0] <= fac1[1] * up1[2];  pb2[0] <= fac1[2] * up1[1];
    pa2[1] <= fac1[2] * up1[0];  pb2[1] <= fac1[0] * up1[2];
    pa2[2] <= fac1[0] * up1[1];  pb2[2] <= fac1[1] * up1[0];
  end

  // Stage 3: magnitudes and signs of both axes, and magnitudes of the difference.
  logic [31:0]        dm3 [3];
  logic [63:0]        cm3 [3];
  logic [2:0]         cn3;
  logic [31:0]        lm3 [2];
  logic [1:0]         ln3;
  logic signed [31:0] lis3 [3], src3 [3];
  logic signed [64:0] cd [3];
  logic signed [32:0] dabs [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cd[k]   = 65'(pa2[k]) - 65'(pb2[k]);
      dabs[k] = (d2[k] < 0) ? -d2[k] : d2[k];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      dm3[k]  <= dabs[k][31:0];
      cm3[k]  <= (cd[k] < 0) ? 64'(-cd[k]) : 64'(cd[k]);
      cn3[k]  <= (pa2[k] < pb2[k]);
      lis3[k] <= lis2[k];
      src3[k] <= src2[k];
    end
    lm3[0] <= dabs[1][31:0];
    ln3[0] <= (d2[1] > 0);
    lm3[1] <= dabs[0][31:0];
    ln3[1] <= (d2[0] < 0);
  end

  // Stage 4: squares of the difference and leading-one search for each axis.
  logic [63:0]        sq4 [3];
  logic [63:0]        cm4 [3];
  logic [31:0]        lm4 [2];
  logic [2:0]         cn4;
  logic [1:0]         ln4;
  logic [5:0]         pa4;
  logic [4:0]         pl4;
  logic               za4, zl4;
  logic signed [31:0] lis4 [3], src4 [3];
  logic [63:0]        ora;
  logic [31:0]        orl;
  logic [5:0]         posa;
  logic [4:0]         posl;

  always_comb begin
    ora  = cm3[0] | cm3[1] | cm3[2];
    orl  = lm3[0] | lm3[1];
    posa = '0;
    posl = '0;
    for (int i = 0; i < 64; i++) if (ora[i]) posa = 6'(i);
    for (int i = 0; i < 32; i++) if (orl[i]) posl = 5'(i);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      sq4[k]  <= 64'(dm3[k]) * 64'(dm3[k]);
      cm4[k]  <= cm3[k];
      lis4[k] <= lis3[k];
      src4[k] <= src3[k];
    end
    lm4[0] <= lm3[0];
    lm4[1] <= lm3[1];
    cn4    <= cn3;
    ln4    <= ln3;
    pa4    <= posa;
    pl4    <= posl;
    za4    <= (ora == '0);
    zl4    <= (orl == '0);
  end

  // Stage 5: distance sum and shift of each axis so its top bit sits at bit 30.
  logic [SqW-1:0] dsum5;
  mid_t           mid5;

  always_ff @(posedge clk) begin
    dsum5 <= SqW'(sq4[0]) + SqW'(sq4[1]) + SqW'(sq4[2]);
    for (int k = 0; k < 3; k++) begin
      mid5.lis[k] <= lis4[k];
      mid5.src[k] <= src4[k];
      if (pa4 > 6'd30) mid5.na[k] <= 31'(cm4[k] >> (pa4 - 6'd30));
      else             mid5.na[k] <= 31'(cm4[k] << (6'd30 - pa4));
    end
    for (int k = 0; k < 2; k++) begin
      if (pl4 > 5'd30) mid5.nl[k] <= 31'(lm4[k] >> 1);
      else             mid5.nl[k] <= 31'(lm4[k] << (5'd30 - pl4));
    end
    mid5.nega  <= cn4;
    mid5.negl  <= ln4;
    mid5.zeroa <= za4;
    mid5.zerol <= zl4;
  end

  // Stage 6: squares of the normalized axis components.
  logic [SqW-1:0] dsum6;
  logic [61:0]    sa6 [3];
  logic [61:0]    sl6 [2];
  mid_t           mid6;

  always_ff @(posedge clk) begin
    dsum6 <= dsum5;
    mid6  <= mid5;
    for (int k = 0; k < 3; k++) sa6[k] <= 62'(mid5.na[k]) * 62'(mid5.na[k]);
    for (int k = 0; k < 2; k++) sl6[k] <= 62'(mid5.nl[k]) * 62'(mid5.nl[k]);
  end

  // Square roots: distance and the two axis lengths side by side.
  logic [SqW-1:0] rad [3];
  logic [RtW-1:0] root [3];
  logic           sv;
  mid_t           stag;

  always_comb begin
    rad[0] = dsum6;
    rad[1] = SqW'(sa6[0]) + SqW'(sa6[1]) + SqW'(sa6[2]);
    rad[2] = SqW'(sl6[0]) + SqW'(sl6[1]);
  end

  sepu_isqrt #(
    .InW   (SqW),
    .Lanes (3),
    .TagW  ($bits(mid_t))
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v6),
    .rad       (rad),
    .in_tag    (mid6),
    .out_valid (sv),
    .root      (root),
    .out_tag   (stag)
  );

  // Stage 8: sideways distance product and zone decision.
  logic [63:0]      prod8;
  logic [1:0]       zone8;
  logic [NumW-1:0]  fnum8;
  logic [31:0]      lena8, lenl8;
  mid_t             mid8;
  logic [RtW-1:0]   dist_rel;
  logic [RtW-1:0]   zone_hi;

  always_comb begin
    dist_rel = root[0] - RtW'(ambient_distance);
    zone_hi  = RtW'(ambient_distance) + RtW'(transition_width);
  end

  always_ff @(posedge clk) begin
    prod8 <= 64'(root[0]) * 64'(separation_tangent);
    if (root[0] <= RtW'(ambient_distance)) zone8 <= ZONE_AMBIENT;
    else if (root[0] >= zone_hi)            zone8 <= ZONE_LOCAL;
    else                                    zone8 <= ZONE_BLEND;
    fnum8 <= {dist_rel[30:0], 16'h0000};
    lena8 <= root[1][31:0];
    lenl8 <= root[2][31:0];
    mid8  <= stag;
  end

  // Stage 9: clamp the sideways distance to the separation limits.
  logic [30:0]     dist_out9;
  logic [1:0]      zone9;
  logic [NumW-1:0] fnum9;
  logic [31:0]     lena9, lenl9;
  mid_t            mid9;

  always_ff @(posedge clk) begin
    if (prod8[63:16] > 48'(max_separation))      dist_out9 <= max_separation;
    else if (prod8[63:16] < 48'(min_separation)) dist_out9 <= min_separation;
    else                                         dist_out9 <= prod8[46:16];
    zone9 <= zone8;
    fnum9 <= fnum8;
    lena9 <= lena8;
    lenl9 <= lenl8;
    mid9  <= mid8;
  end

  // Divider: unit axis components and the blend fraction.
  logic [NumW-1:0] dnum [DivLanes];
  logic [DenW-1:0] dden [DivLanes];
  logic [QW-1:0]   quo  [DivLanes];
  post_t           ptag_in, ptag;
  logic            dv;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dnum[k] = {mid9.na[k], 16'h0000};
      dden[k] = lena9;
    end
    for (int k = 0; k < 2; k++) begin
      dnum[3+k] = {mid9.nl[k], 16'h0000};
      dden[3+k] = lenl9;
    end
    dnum[5] = fnum9;
    dden[5] = DenW'(transition_width);
    ptag_in.lis      = mid9.lis;
    ptag_in.src      = mid9.src;
    ptag_in.nega     = mid9.nega;
    ptag_in.negl     = mid9.negl;
    ptag_in.zeroa    = mid9.zeroa;
    ptag_in.zerol    = mid9.zerol;
    ptag_in.dist_out = dist_out9;
    ptag_in.zone     = zone9;
  end

  sepu_div #(
    .NumW  (NumW),
    .DenW  (DenW),
    .QW    (QW),
    .Lanes (DivLanes),
    .TagW  ($bits(post_t))
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v9),
    .num       (dnum),
    .den       (dden),
    .in_tag    (ptag_in),
    .out_valid (dv),
    .quo       (quo),
    .out_tag   (ptag)
  );

  // Stage 10: scale the unit axes by their offsets.
  logic [30:0]        oa10 [3];
  logic [30:0]        ol10 [2];
  logic [2:0]         sa10;
  logic [1:0]         sl10;
  logic [15:0]        frac10;
  logic [1:0]         zone10;
  logic signed [31:0] lis10 [3], src10 [3];
  logic [47:0]        pra [3];
  logic [47:0]        prl [2];

  always_comb begin
    for (int k = 0; k < 3; k++) pra[k] = 48'(quo[k]) * 48'(min_separation);
    for (int k = 0; k < 2; k++) prl[k] = 48'(quo[3+k]) * 48'(ptag.dist_out);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      oa10[k]  <= ptag.zeroa ? '0 : pra[k][46:16];
      sa10[k]  <= ptag.nega[k] ^ left_channel;
      lis10[k] <= ptag.lis[k];
      src10[k] <= ptag.src[k];
    end
    for (int k = 0; k < 2; k++) begin
      ol10[k] <= ptag.zerol ? '0 : prl[k][46:16];
      sl10[k] <= ptag.negl[k] ^ left_channel;
    end
    frac10 <= quo[5][15:0];
    zone10 <= ptag.zone;
  end

  // Stage 11: ambient and localized positions.
  logic signed [33:0] amb11 [3], loc11 [3];
  logic [15:0]        frac11;
  logic [1:0]         zone11;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (sa10[k]) amb11[k] <= 34'(lis10[k]) - $signed({3'b000, oa10[k]});
      else         amb11[k] <= 34'(lis10[k]) + $signed({3'b000, oa10[k]});
    end
    for (int k = 0; k < 2; k++) begin
      if (sl10[k]) loc11[k] <= 34'(src10[k]) - $signed({3'b000, ol10[k]});
      else         loc11[k] <= 34'(src10[k]) + $signed({3'b000, ol10[k]});
    end
    loc11[2] <= 34'(src10[2]);
    frac11   <= frac10;
    zone11   <= zone10;
  end

  // Stage 12: magnitude and sign of the localized-minus-ambient step.
  logic signed [33:0] amb12 [3], loc12 [3];
  logic [33:0]        dmag12 [3];
  logic [2:0]         dneg12;
  logic [15:0]        frac12;
  logic [1:0]         zone12;
  logic signed [34:0] diff [3];

  always_comb begin
    for (int k = 0; k < 3; k++) diff[k] = 35'(loc11[k]) - 35'(amb11[k]);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      dmag12[k] <= (diff[k] < 0) ? 34'(-diff[k]) : 34'(diff[k]);
      dneg12[k] <= (diff[k] < 0);
      amb12[k]  <= amb11[k];
      loc12[k]  <= loc11[k];
    end
    frac12 <= frac11;
    zone12 <= zone11;
  end

  // Stage 13: blend product.
  logic [49:0]        bp13 [3];
  logic [2:0]         dneg13;
  logic signed [33:0] amb13 [3], loc13 [3];
  logic [1:0]         zone13;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      bp13[k]  <= 50'(dmag12[k]) * 50'(frac12);
      amb13[k] <= amb12[k];
      loc13[k] <= loc12[k];
    end
    dneg13 <= dneg12;
    zone13 <= zone12;
  end

  // Stage 14: pick the zone's position and saturate to 32 bits.
  logic signed [35:0] pick [3];
  logic signed [35:0] step [3];
  logic [31:0]        sat [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      step[k] = $signed({2'b00, bp13[k][49:16]});
      case (zone13)
        ZONE_AMBIENT: pick[k] = 36'(amb13[k]);
        ZONE_LOCAL:   pick[k] = 36'(loc13[k]);
        default:      pick[k] = dneg13[k] ? 36'(amb13[k]) - step[k]
                                          : 36'(amb13[k]) + step[k];
      endcase
      if (pick[k] > 36'sd2147483647)       sat[k] = 32'h7FFF_FFFF;
      else if (pick[k] < -36'sd2147483648) sat[k] = 32'h8000_0000;
      else                                 sat[k] = pick[k][31:0];
    end
  end

  always_ff @(posedge clk) begin
    placed_x <= sat[0];
    placed_y <= sat[1];
    placed_z <= sat[2];
    zone     <= zone13;
  end

  // Valid chain for the stages around the shared units.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0;
      v8 <= 1'b0; v9 <= 1'b0; v10 <= 1'b0; v11 <= 1'b0; v12 <= 1'b0;
      v13 <= 1'b0; done <= 1'b0;
    end else begin
      v1 <= start && !busy;
      v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4; v6 <= v5;
      v8 <= sv; v9 <= v8;
      v10 <= dv; v11 <= v10; v12 <= v11; v13 <= v12;
      done <= v13;
    end
  end

  // A blended item always has a fraction below one.
  assert property (@(posedge clk) disable iff (rst)
    dv && (ptag.zone == ZONE_BLEND) |-> (quo[5][QW-1] == 1'b0))
    else $error("blend fraction reached one");

  // A nonzero ambient axis has a normalized length of at least one half.
  assert property (@(posedge clk) disable iff (rst)
    sv && !stag.zeroa |-> (root[1][RtW-1:32] == '0) && (root[1][31:30] != 2'b00))
    else $error("ambient axis length out of range");

  // The same holds for the localized axis.
  assert property (@(posedge clk) disable iff (rst)
    sv && !stag.zerol |-> (root[2][RtW-1:32] == '0) && (root[2][31:30] != 2'b00))
    else $error("localized axis length out of range");

endmodule

FILE: hdl/sepu_isqrt.sv
// Pipelined integer square root, one result bit per stage, several lanes.
module sepu_isqrt #(
  parameter int InW   = 66,
  parameter int Lanes = 3,
  parameter int TagW  = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [InW-1:0]       rad [Lanes],
  input  logic [TagW-1:0]      in_tag,
  output logic                 out_valid,
  output logic [InW/2-1:0]     root [Lanes],
  output logic [TagW-1:0]      out_tag
);

  localparam int RootW  = InW / 2;
  localparam int RemW   = RootW + 2;
  localparam int Stages = RootW;

  logic                vld_q  [Stages+1];
  logic [TagW-1:0]     tag_q  [Stages+1];
  logic [InW-1:0]      rad_q  [Stages+1][Lanes];
  logic [RootW-1:0]    root_q [Stages+1][Lanes];
  logic [RemW-1:0]     rem_q  [Stages+1][Lanes];
  logic [RemW-1:0]     rem_sh [Stages][Lanes];
  logic [RemW-1:0]     trial  [Stages][Lanes];

  // Bring down the next two radicand bits and form the trial subtrahend.
  always_comb begin
    for (int s = 0; s < Stages; s++) begin
      for (int l = 0; l < Lanes; l++) begin
        rem_sh[s][l] = {rem_q[s][l][RemW-3:0], rad_q[s][l][InW-1:InW-2]};
        trial[s][l]  = {root_q[s][l], 2'b01};
      end
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= Stages; s++) vld_q[s] <= 1'b0;
    end else begin
      vld_q[0] <= in_valid;
      for (int s = 0; s < Stages; s++) vld_q[s+1] <= vld_q[s];
    end
  end

  // Input register, then one root bit per stage.
  always_ff @(posedge clk) begin
    tag_q[0] <= in_tag;
    for (int l = 0; l < Lanes; l++) begin
      rad_q[0][l]  <= rad[l];
      root_q[0][l] <= '0;
      rem_q[0][l]  <= '0;
    end
    for (int s = 0; s < Stages; s++) begin
      tag_q[s+1] <= tag_q[s];
      for (int l = 0; l < Lanes; l++) begin
        rad_q[s+1][l] <= rad_q[s][l] << 2;
        if (rem_sh[s][l] >= trial[s][l]) begin
          rem_q[s+1][l]  <= rem_sh[s][l] - trial[s][l];
          root_q[s+1][l] <= {root_q[s][l][RootW-2:0], 1'b1};
        end else begin
          rem_q[s+1][l]  <= rem_sh[s][l];
          root_q[s+1][l] <= {root_q[s][l][RootW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = vld_q[Stages];
  assign out_tag   = tag_q[Stages];
  always_comb begin
    for (int l = 0; l < Lanes; l++) root[l] = root_q[Stages][l];
  end

endmodule

FILE: hdl/sepu_div.sv
// Pipelined restoring divider, one quotient bit per stage, several lanes.
// The quotient must fit in QW bits, so the dividend's upper part is below the divisor.
module sepu_div #(
  parameter int NumW  = 47,
  parameter int DenW  = 32,
  parameter int QW    = 17,
  parameter int Lanes = 6,
  parameter int TagW  = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [NumW-1:0]   num [Lanes],
  input  logic [DenW-1:0]   den [Lanes],
  input  logic [TagW-1:0]   in_tag,
  output logic              out_valid,
  output logic [QW-1:0]     quo [Lanes],
  output logic [TagW-1:0]   out_tag
);

  localparam int RemW = DenW + 1;

  logic              vld_q [QW+1];
  logic [TagW-1:0]   tag_q [QW+1];
  logic [QW-1:0]     low_q [QW+1][Lanes];
  logic [DenW-1:0]   den_q [QW+1][Lanes];
  logic [RemW-1:0]   rem_q [QW+1][Lanes];
  logic [QW-1:0]     quo_q [QW+1][Lanes];
  logic [RemW-1:0]   rem_sh [QW][Lanes];

  // Shift the next dividend bit into the partial remainder.
  always_comb begin
    for (int s = 0; s < QW; s++) begin
      for (int l = 0; l < Lanes; l++) begin
        rem_sh[s][l] = {rem_q[s][l][DenW-1:0], low_q[s][l][QW-1]};
      end
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= QW; s++) vld_q[s] <= 1'b0;
    end else begin
      vld_q[0] <= in_valid;
      for (int s = 0; s < QW; s++) vld_q[s+1] <= vld_q[s];
    end
  end

  // Input register, then one compare and subtract per stage.
  always_ff @(posedge clk) begin
    tag_q[0] <= in_tag;
    for (int l = 0; l < Lanes; l++) begin
      rem_q[0][l] <= RemW'(num[l][NumW-1:QW]);
      low_q[0][l] <= num[l][QW-1:0];
      den_q[0][l] <= den[l];
      quo_q[0][l] <= '0;
    end
    for (int s = 0; s < QW; s++) begin
      tag_q[s+1] <= tag_q[s];
      for (int l = 0; l < Lanes; l++) begin
        low_q[s+1][l] <= low_q[s][l] << 1;
        den_q[s+1][l] <= den_q[s][l];
        if (rem_sh[s][l] >= {1'b0, den_q[s][l]}) begin
          rem_q[s+1][l] <= rem_sh[s][l] - {1'b0, den_q[s][l]};
          quo_q[s+1][l] <= {quo_q[s][l][QW-2:0], 1'b1};
        end else begin
          rem_q[s+1][l] <= rem_sh[s][l];
          quo_q[s+1][l] <= {quo_q[s][l][QW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = vld_q[QW];
  assign out_tag   = tag_q[QW];
  always_comb begin
    for (int l = 0; l < Lanes; l++) quo[l] = quo_q[QW][l];
  end

endmodule

FILE: verif/stereo_emitter_placement_unit_tb.sv
// Self-checking testbench for the stereo emitter placement unit.
`timescale 1ns / 100ps

module stereo_emitter_placement_unit_tb;
  import sepu_pkg::*;

  localparam int PIPE_DRAIN = 80;

  // One input transaction: listener, facing, up and source, each x/y/z.
  typedef struct {
    logic [31:0] lis[3];
    logic [31:0] fac[3];
    logic [31:0] up[3];
    logic [31:0] src[3];
  } pose_t;

  // One expected placement.
  typedef struct {
    logic [31:0] pos[3];
    logic [1:0]  zone;
  } placement_t;

  // Keeps a mirror of the registers, predicts placements and checks results.
  class placement_board;
    logic [30:0] ambient, trans, max_sep, min_sep, tangent;
    logic        left;
    placement_t  pending[$];
    int          errors;
    int          checked;
    int          zone_seen[3];

    function void set_reg(logic [IdxW-1:0] idx, logic [31:0] val);
      case (idx)
        REG_AMBIENT: ambient = val[30:0];
        REG_TRANS:   trans   = val[30:0];
        REG_MAX_SEP: max_sep = val[30:0];
        REG_MIN_SEP: min_sep = val[30:0];
        REG_TANGENT: tangent = val[30:0];
        REG_LEFT:    left    = val[0];
        default: ;
      endcase
    endfunction

    function logic [63:0] int_sqrt(logic [127:0] v);
      logic [127:0] root, rem, trial;
      root = 0;
      rem = 0;
      for (int i = 63; i >= 0; i--) begin
        rem = (rem << 2) | ((v >> (2 * i)) & 128'd3);
        trial = (root << 2) | 128'd1;
        if (rem >= trial) begin
          rem -= trial;
          root = (root << 1) | 128'd1;
        end else begin
          root = root << 1;
        end
      end
      return root[63:0];
    endfunction

    // Unit vector in Q16.16 from magnitudes and signs.
    function void unit_vec(logic [63:0] mag_in[3], bit neg[3], output longint u[3]);
      logic [63:0]  m, mag[3], sum, len;
      int           rsh, lsh;
      longint       q;
      rsh = 0;
      lsh = 0;
      m = mag_in[0];
      if (mag_in[1] > m) m = mag_in[1];
      if (mag_in[2] > m) m = mag_in[2];
      if (m == 0) begin
        for (int k = 0; k < 3; k++) u[k] = 0;
        return;
      end
      while (m >= 64'h8000_0000) begin m = m >> 1; rsh++; end
      while (m < 64'h4000_0000) begin m = m << 1; lsh++; end
      sum = 0;
      for (int k = 0; k < 3; k++) begin
        mag[k] = (mag_in[k] >> rsh) << lsh;
        sum += mag[k] * mag[k];
      end
      len = int_sqrt({64'd0, sum});
      for (int k = 0; k < 3; k++) begin
        q = longint'((mag[k] << 16) / len);
        u[k] = neg[k] ? -q : q;
      end
    endfunction

    // Signed value times unsigned Q16.16, truncated toward zero.
    function longint scale_q16(longint u, logic [63:0] s);
      logic [127:0] p;
      logic [63:0]  a;
      a = (u < 0) ? 64'(-u) : 64'(u);
      p = ({64'd0, a} * {64'd0, s}) >> 16;
      return (u < 0) ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function logic [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
    endfunction

    function placement_t place(pose_t p);
      placement_t   r;
      longint       lis[3], src[3], d[3], ua[3], ul[3], amb[3], loc[3], res[3];
      longint       fa[3], ub[3], oa, ol;
      logic signed [65:0] cr;
      logic [63:0]  mag[3], distance, dist_out, frac, a64;
      logic [127:0] sq;
      bit           neg[3];
      sq = 0;
      for (int k = 0; k < 3; k++) begin
        lis[k] = longint'($signed(p.lis[k]));
        src[k] = longint'($signed(p.src[k]));
        fa[k]  = longint'($signed(p.fac[k]));
        ub[k]  = longint'($signed(p.up[k]));
        d[k]   = lis[k] - src[k];
        a64 = (d[k] < 0) ? 64'(-d[k]) : 64'(d[k]);
        sq += {64'd0, a64} * {64'd0, a64};
      end
      distance = int_sqrt(sq);
      // Ambient axis: facing cross up.
      for (int k = 0; k < 3; k++) begin
        cr = 66'(fa[(k + 1) % 3] * ub[(k + 2) % 3]) - 66'(fa[(k + 2) % 3] * ub[(k + 1) % 3]);
        neg[k] = cr < 0;
        mag[k] = neg[k] ? 64'(-cr) : 64'(cr);
      end
      unit_vec(mag, neg, ua);
      // Localized axis: horizontal perpendicular of the offset.
      mag[0] = (d[1] < 0) ? 64'(-d[1]) : 64'(d[1]);
      neg[0] = d[1] > 0;
      mag[1] = (d[0] < 0) ? 64'(-d[0]) : 64'(d[0]);
      neg[1] = d[0] < 0;
      mag[2] = 0;
      neg[2] = 0;
      unit_vec(mag, neg, ul);
      dist_out = 64'((128'(distance) * 128'(tangent)) >> 16);
      if (dist_out > 64'(max_sep)) dist_out = 64'(max_sep);
      else if (dist_out < 64'(min_sep)) dist_out = 64'(min_sep);
      for (int k = 0; k < 3; k++) begin
        oa = scale_q16(ua[k], 64'(min_sep));
        ol = scale_q16(ul[k], dist_out);
        amb[k] = lis[k] + (left ? -oa : oa);
        loc[k] = src[k] + (left ? -ol : ol);
      end
      if (distance <= 64'(ambient)) begin
        r.zone = ZONE_AMBIENT;
        for (int k = 0; k < 3; k++) res[k] = amb[k];
      end else if (distance >= 64'(ambient) + 64'(trans)) begin
        r.zone = ZONE_LOCAL;
        for (int k = 0; k < 3; k++) res[k] = loc[k];
      end else begin
        r.zone = ZONE_BLEND;
        frac = ((distance - 64'(ambient)) << 16) / 64'(trans);
        for (int k = 0; k < 3; k++) res[k] = amb[k] + scale_q16(loc[k] - amb[k], frac);
      end
      for (int k = 0; k < 3; k++) r.pos[k] = clamp32(res[k]);
      return r;
    endfunction

    function void note_item(pose_t p);
      pending.push_back(place(p));
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    endtask

    task check_result(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [1:0] zn);
      placement_t w;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result", {30'd0, zn}, 32'd0);
        return;
      end
      w = pending.pop_front();
      checked++;
      if (w.zone <= ZONE_BLEND) zone_seen[w.zone]++;
      if (x !== w.pos[0]) report_mismatch("placed_x", x, w.pos[0]);
      if (y !== w.pos[1]) report_mismatch("placed_y", y, w.pos[1]);
      if (z !== w.pos[2]) report_mismatch("placed_z", z, w.pos[2]);
      if (zn !== w.zone) report_mismatch("zone", {30'd0, zn}, {30'd0, w.zone});
    endtask
  endclass

  logic clk, rst, start, busy, done, cfg_valid, cfg_ready;
  logic signed [DataW-1:0] listener_x, listener_y, listener_z;
  logic signed [DataW-1:0] facing_x, facing_y, facing_z;
  logic signed [DataW-1:0] up_x, up_y, up_z;
  logic signed [DataW-1:0] source_x, source_y, source_z;
  logic signed [DataW-1:0] placed_x, placed_y, placed_z;
  logic [1:0]       zone;
  logic [IdxW-1:0]  cfg_index;
  logic [DataW-1:0] cfg_data;

  placement_board board = new();
  int             items_sent;
  bit             quiet;

  stereo_emitter_placement_unit dut (.*);

  // Clock generation.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Record every accepted input transaction.
  always @(posedge clk) begin
    if (!rst && start && !busy) begin
      pose_t p;
      p.lis = '{listener_x, listener_y, listener_z};
      p.fac = '{facing_x, facing_y, facing_z};
      p.up  = '{up_x, up_y, up_z};
      p.src = '{source_x, source_y, source_z};
      board.note_item(p);
    end
  end

  // Mirror register writes.
  always @(posedge clk) begin
    if (!rst && cfg_valid && cfg_ready) board.set_reg(cfg_index, cfg_data);
  end

  // Check each result transaction.
  always @(posedge clk) begin
    if (!rst && done) board.check_result(placed_x, placed_y, placed_z, zone);
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_item(pose_t p);
    bit held;
    int gap;
    listener_x <= p.lis[0]; listener_y <= p.lis[1]; listener_z <= p.lis[2];
    facing_x   <= p.fac[0]; facing_y   <= p.fac[1]; facing_z   <= p.fac[2];
    up_x       <= p.up[0];  up_y       <= p.up[1];  up_z       <= p.up[2];
    source_x   <= p.src[0]; source_y   <= p.src[1]; source_z   <= p.src[2];
    start <= 1'b1;
    do begin
      @(negedge clk);
      held = busy;
      @(posedge clk);
    end while (held);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Each write ends with an idle gap so valid drops between writes.
  task automatic write_reg(logic [IdxW-1:0] idx, logic [31:0] val);
    bit rdy;
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do begin
      @(negedge clk);
      rdy = cfg_ready;
      @(posedge clk);
    end while (!rdy);
    cfg_valid <= 1'b0;
    repeat ($urandom_range(1, 3)) @(posedge clk);
  endtask

  // Let the pipeline empty so that registers may change.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  // Write a full register set; the spare bit 31 is randomized to check masking.
  task automatic configure(logic [30:0] a, logic [30:0] t, logic [30:0] mx,
                           logic [30:0] mn, logic [30:0] tg, bit lf);
    drain();
    write_reg(REG_AMBIENT, {1'($urandom), a});
    write_reg(REG_TRANS,   {1'($urandom), t});
    write_reg(REG_MAX_SEP, {1'($urandom), mx});
    write_reg(REG_MIN_SEP, {1'($urandom), mn});
    write_reg(REG_TANGENT, {1'($urandom), tg});
    write_reg(REG_LEFT,    {31'($urandom), lf});
    // Indexes past the register list must be ignored.
    write_reg(3'd6, $urandom);
    write_reg(3'd7, $urandom);
  endtask

  function automatic logic [31:0] any_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'(int'($urandom_range(0, 8 << 16)) - (4 << 16));
      default: return $urandom;
    endcase
  endfunction

  // Well-formed pose: moderate vectors, source placed around the blend band.
  function automatic pose_t make_pose();
    pose_t  p;
    longint span, base, off;
    span = longint'(board.ambient) + longint'(board.trans);
    if (span < (1 << 16)) span = 1 << 16;
    if (span > 64'd1 << 30) span = 64'd1 << 30;
    for (int k = 0; k < 3; k++) begin
      base = longint'($signed(32'(int'($urandom_range(0, 200 << 16)) - (100 << 16))));
      off = longint'($urandom_range(0, 32'(span + span / 2))) / 2;
      if ($urandom_range(0, 1)) off = -off;
      p.lis[k] = base[31:0];
      p.src[k] = 32'(base + off);
      p.fac[k] = 32'(int'($urandom_range(0, 4 << 16)) - (2 << 16));
      p.up[k]  = 32'(int'($urandom_range(0, 4 << 16)) - (2 << 16));
    end
    case ($urandom_range(0, 9))
      0: p.up = p.fac;
      1: begin p.src[0] = p.lis[0]; p.src[1] = p.lis[1]; end
      default: ;
    endcase
    return p;
  endfunction

  function automatic pose_t noise_pose();
    pose_t p;
    for (int k = 0; k < 3; k++) begin
      p.lis[k] = any_word();
      p.fac[k] = any_word();
      p.up[k]  = any_word();
      p.src[k] = any_word();
    end
    return p;
  endfunction

  task automatic run_random(int count);
    for (int i = 0; i < count; i++)
      send_item(($urandom_range(0, 99) < 75) ? make_pose() : noise_pose());
  endtask

  task automatic run_directed();
    pose_t p;
    logic [31:0] ext[4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};
    // Field extremes.
    foreach (ext[i]) begin
      p.lis = '{ext[i], ext[i], ext[i]};
      p.fac = '{ext[i], ext[(i + 1) % 4], ext[(i + 2) % 4]};
      p.up  = '{ext[(i + 3) % 4], ext[i], ext[(i + 1) % 4]};
      p.src = '{ext[(i + 1) % 4], ext[(i + 2) % 4], ext[(i + 3) % 4]};
      send_item(p);
    end
    // Listener and source at opposite corners of the range.
    p.lis = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
    p.src = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    send_item(p);
    // Zero facing: no ambient axis.
    p = make_pose();
    p.fac = '{32'd0, 32'd0, 32'd0};
    send_item(p);
    // Source straight above, then straight below.
    p = make_pose();
    p.src = '{p.lis[0], p.lis[1], 32'(p.lis[2] + (7 << 16))};
    send_item(p);
    p.src[2] = 32'(p.lis[2] - (7 << 16));
    send_item(p);
    // Distance exactly at the ambient edge and at the localized edge, then just past the ambient edge.
    p = make_pose();
    p.src = '{32'(p.lis[0] - board.ambient), p.lis[1], p.lis[2]};
    send_item(p);
    p.src[0] = 32'(p.lis[0] - board.ambient - board.trans);
    send_item(p);
    p.src[0] = 32'(p.lis[0] - board.ambient - 1);
    send_item(p);
    // Listener near the ends of the range so offsets saturate.
    p = make_pose();
    p.lis = '{32'h7FFF_FFF0, 32'h8000_0010, 32'h7FFF_FFF0};
    send_item(p);
    p.src = '{32'h7FFF_FFF0, 32'h8000_0010, 32'h0000_0000};
    send_item(p);
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    {listener_x, listener_y, listener_z} = '0;
    {facing_x, facing_y, facing_z} = '0;
    {up_x, up_y, up_z} = '0;
    {source_x, source_y, source_z} = '0;
    board.set_reg(REG_AMBIENT, 0);
    board.set_reg(REG_TRANS, 0);
    board.set_reg(REG_MAX_SEP, 0);
    board.set_reg(REG_MIN_SEP, 0);
    board.set_reg(REG_TANGENT, 0);
    board.set_reg(REG_LEFT, 0);
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset values first, then a typical setting for the directed items.
    run_random(60);
    configure(31'(5 << 16), 31'(10 << 16), 31'(3 << 16), 31'(1 << 15), 31'(1 << 14), 1'b0);
    run_directed();
    run_random(150);

    // Extremes of every register.
    configure('1, '1, '1, '1, '1, 1'b1);
    run_directed();
    run_random(120);
    configure(31'd0, '1, '1, 31'd0, '1, 1'b0);
    run_random(120);
    configure(31'd0, 31'd0, 31'd0, '1, 31'd0, 1'b1);
    quiet = 1'b1;
    run_random(120);
    quiet = 1'b0;

    // Random settings; min above max now and then.
    for (int ph = 0; ph < 9; ph++) begin
      configure(31'($urandom_range(0, 30 << 16)),
                ($urandom_range(0, 5) == 0) ? 31'd0 : 31'($urandom_range(1, 40 << 16)),
                31'($urandom_range(0, 8 << 16)), 31'($urandom_range(0, 4 << 16)),
                31'($urandom_range(0, 2 << 16)), 1'($urandom));
      quiet = (ph == 4);
      run_random(130);
    end
    quiet = 1'b0;

    start <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);

    $display("Sent %0d poses over 14 register settings; checked %0d placements.",
             items_sent, board.checked);
    $display("Zones seen: ambient %0d, localized %0d, blended %0d; mismatches %0d.",
             board.zone_seen[0], board.zone_seen[1], board.zone_seen[2], board.errors);
    if (board.errors == 0) begin
      $display("stereo_emitter_placement_unit test passed");
    end else begin
      $display("stereo_emitter_placement_unit test failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #20ms;
    $display("Timeout with %0d results outstanding.", board.pending.size());
    $display("stereo_emitter_placement_unit test failed");
    $finish;
  end

endmodule
